// ===== rtl/tmms_pkg.sv =====
// ----------------------------------------------------------------------------
// tmms_pkg
// Shared constants, types and register codes of the trimmed-mean smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package tmms_pkg;

  localparam int unsigned SAMPLES_PER_WINDOW = 16;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned BAT_W    = 13;
  localparam int unsigned AGG_W    = 8;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned NOM_W    = 13;
  localparam int unsigned DROP_W   = 10;
  localparam int unsigned COMP_W   = 16;
  localparam int unsigned FILT_W   = 24;

  localparam int unsigned SUM_W  = $clog2(SAMPLES_PER_WINDOW) + SAMPLE_W;
  localparam int unsigned CNT_W  = $clog2(SAMPLES_PER_WINDOW);
  localparam int unsigned PROD_W = SAMPLE_W + NOM_W;
  localparam int unsigned DVD_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;
  localparam int unsigned DVS_W  = BAT_W;
  localparam int unsigned DIV_CNT_W = $clog2(DVD_W + 1);

  // trimmed mean divide by a reciprocal multiply, exact for any SUM_W-bit sum
  localparam int unsigned TRIM_DIV    = SAMPLES_PER_WINDOW - 2;
  localparam int unsigned TRIM_SHIFT  = SUM_W + $clog2(TRIM_DIV);
  localparam int unsigned RECIP_W     = SUM_W + 1;
  localparam int unsigned TRIM_PROD_W = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] TRIM_RECIP =
    RECIP_W'(((64'd1 << TRIM_SHIFT) + 64'(TRIM_DIV) - 64'd1) / 64'(TRIM_DIV));

  localparam int unsigned MUL_P_W = COEF_W + FILT_W;
  localparam int unsigned ACC_W   = MUL_P_W + 2;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned WQ_DEPTH = 4;
  localparam int unsigned WQ_PTR_W = $clog2(WQ_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AGG_COUNT     = 3'd0,
    REG_COEF_NEW      = 3'd1,
    REG_COEF_PREV     = 3'd2,
    REG_COEF_FEEDBACK = 3'd3,
    REG_NOMINAL_MV    = 3'd4,
    REG_DROPOUT_MV    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [AGG_W-1:0]  agg_count;
    logic [COEF_W-1:0] coef_new;
    logic [COEF_W-1:0] coef_prev;
    logic [COEF_W-1:0] coef_feedback;
    logic [NOM_W-1:0]  nominal_mv;
    logic [DROP_W-1:0] dropout_mv;
  } cfg_t;

  // one finished window: trimmed numerator and the battery seen at its end
  typedef struct packed {
    logic [SUM_W-1:0] num;
    logic [BAT_W-1:0] battery;
  } win_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_TDIV,
    BK_COMP,
    BK_CDIV,
    BK_MUL_NEW,
    BK_MUL_PREV,
    BK_MUL_FB,
    BK_FINISH,
    BK_EMIT
  } back_state_e;

endpackage

`default_nettype wire

// ===== rtl/tmms_front.sv =====
// ----------------------------------------------------------------------------
// tmms_front
// Takes samples, keeps window sum, minimum and maximum, and queues one
// trimmed numerator per finished window.
// ----------------------------------------------------------------------------
`default_nettype none

module tmms_front import tmms_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire logic [SAMPLE_W-1:0] sample_mv_i,
  input  wire logic [BAT_W-1:0]    battery_mv_i,
  output logic                     full_o,
  input  wire logic                wq_full_i,
  output logic                     wq_push_o,
  output win_t                     wq_data_o
);

  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SAMPLE_W-1:0] low_q, low_d;
  logic [SAMPLE_W-1:0] high_q, high_d;

  logic [SUM_W-1:0]    sum_next;
  logic [SAMPLE_W-1:0] low_next, high_next;
  logic                accept, last;

  assign full_o   = wq_full_i;
  assign accept   = push_i && !wq_full_i;
  assign last     = (cnt_q == CNT_W'(SAMPLES_PER_WINDOW - 1));
  assign sum_next = sum_q + SUM_W'(sample_mv_i);
  assign low_next  = (sample_mv_i < low_q) ? sample_mv_i : low_q;
  assign high_next = (sample_mv_i > high_q) ? sample_mv_i : high_q;

  assign wq_push_o         = accept && last;
  assign wq_data_o.num     = sum_next - SUM_W'(low_next) - SUM_W'(high_next);
  assign wq_data_o.battery = battery_mv_i;

  always_comb begin
    sum_d  = sum_q;
    cnt_d  = cnt_q;
    low_d  = low_q;
    high_d = high_q;
    if (accept) begin
      if (last) begin
        sum_d  = '0;
        cnt_d  = '0;
        low_d  = '1;
        high_d = '0;
      end else begin
        sum_d  = sum_next;
        cnt_d  = cnt_q + CNT_W'(1);
        low_d  = low_next;
        high_d = high_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      cnt_q  <= '0;
      low_q  <= '1;
      high_q <= '0;
    end else begin
      sum_q  <= sum_d;
      cnt_q  <= cnt_d;
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tmms_queue.sv =====
// ----------------------------------------------------------------------------
// tmms_queue
// Small window queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module tmms_queue import tmms_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire win_t data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output win_t      data_o
);

  win_t                mem_q [WQ_DEPTH];
  logic [WQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [WQ_PTR_W:0]   count_q;
  logic                do_push, do_pop;

  assign full_o  = (count_q == (WQ_PTR_W+1)'(WQ_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + WQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + WQ_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (WQ_PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (WQ_PTR_W+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tmms_div.sv =====
// ----------------------------------------------------------------------------
// tmms_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tmms_div import tmms_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [DVD_W-1:0]      quotient_o
);

  logic [DVD_W-1:0]     quo_q;
  logic [DVS_W-1:0]     rem_q;
  logic [DVS_W-1:0]     dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 run_q, done_q;

  logic [DVS_W:0]   shifted;
  logic             ge;
  logic [DVS_W:0]   diff;

  assign shifted    = {rem_q, quo_q[DVD_W-1]};
  assign ge         = (shifted >= {1'b0, dvs_q});
  assign diff       = shifted - {1'b0, dvs_q};
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= {quo_q[DVD_W-2:0], ge};
      rem_q <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= DIV_CNT_W'(DVD_W);
        run_q <= 1'b1;
      end else if (run_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tmms_back.sv =====
// ----------------------------------------------------------------------------
// tmms_back
// Divides window numerators, keeps the least trimmed mean, compensates for
// battery droop, runs the three-term filter and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tmms_back import tmms_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire cfg_t         cfg_i,
  input  wire logic         wq_empty_i,
  input  wire win_t         wq_data_i,
  output logic              wq_pop_o,
  output logic              empty_o,
  input  wire logic         pop_i,
  output logic [COMP_W-1:0] compensated_min_o,
  output logic [FILT_W-1:0] smoothed_o,
  output logic              smoothed_valid_o
);

  back_state_e         state_q, state_d;
  logic [BAT_W-1:0]    bat_q, bat_d;
  logic [SAMPLE_W-1:0] trim_q, trim_d;
  logic [SAMPLE_W-1:0] least_q, least_d;
  logic [AGG_W-1:0]    wd_q, wd_d;
  logic [SAMPLE_W-1:0] m_q, m_d;
  logic [COMP_W-1:0]   c_q, c_d;
  logic [COMP_W-1:0]   prev_q, prev_d;
  logic [FILT_W-1:0]   filt_q, filt_d;
  logic                have_prev_q, have_prev_d;
  logic                res_sv_q, res_sv_d;
  logic [MUL_P_W-1:0]  prod_q, prod_d;
  logic [ACC_W-1:0]    acc_q, acc_d;

  logic                out_valid_q;
  logic [COMP_W-1:0]   out_comp_q;
  logic [FILT_W-1:0]   out_smooth_q;
  logic                out_sv_q;
  logic                load_out;

  logic                div_start, div_done;
  logic [DVD_W-1:0]    div_dvd, div_quo;
  logic [DVS_W-1:0]    div_dvs;

  logic [TRIM_PROD_W-1:0] trim_prod;
  logic [PROD_W-1:0]   comp_prod;
  logic [BAT_W:0]      bat_thresh;
  logic [COEF_W-1:0]   mul_a;
  logic [FILT_W-1:0]   mul_b;
  logic [MUL_P_W-1:0]  mul_p;
  logic [ACC_W-1:0]    acc_sum;
  logic [SAMPLE_W-1:0] least_new;
  logic [AGG_W-1:0]    wd_new;

  tmms_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign trim_prod  = TRIM_PROD_W'(wq_data_i.num) * TRIM_PROD_W'(TRIM_RECIP);
  assign comp_prod  = m_q * cfg_i.nominal_mv;
  assign bat_thresh = {1'b0, cfg_i.nominal_mv} + (BAT_W+1)'(cfg_i.dropout_mv);
  assign mul_p      = mul_a * mul_b;
  assign acc_sum    = acc_q + ACC_W'(prod_q);
  assign least_new  = (trim_q < least_q) ? trim_q : least_q;
  assign wd_new     = wd_q + AGG_W'(1);

  always_comb begin
    state_d     = state_q;
    bat_d       = bat_q;
    trim_d      = trim_q;
    least_d     = least_q;
    wd_d        = wd_q;
    m_d         = m_q;
    c_d         = c_q;
    prev_d      = prev_q;
    filt_d      = filt_q;
    have_prev_d = have_prev_q;
    res_sv_d    = res_sv_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    wq_pop_o    = 1'b0;
    load_out    = 1'b0;
    div_start   = 1'b0;
    div_dvd     = DVD_W'(comp_prod);
    div_dvs     = bat_q - BAT_W'(cfg_i.dropout_mv);
    mul_a       = cfg_i.coef_new;
    mul_b       = {c_q, 8'b0};

    unique case (state_q)
      BK_IDLE: begin
        if (!wq_empty_i) begin
          wq_pop_o = 1'b1;
          trim_d   = trim_prod[TRIM_SHIFT +: SAMPLE_W];
          bat_d    = wq_data_i.battery;
          state_d  = BK_TDIV;
        end
      end
      BK_TDIV: begin
        if (wd_new != cfg_i.agg_count) begin
          least_d = least_new;
          wd_d    = wd_new;
          state_d = BK_IDLE;
        end else begin
          m_d     = least_new;
          least_d = '1;
          wd_d    = '0;
          state_d = BK_COMP;
        end
      end
      BK_COMP: begin
        priority if (!have_prev_q) begin
          // first result passes through and leaves the filter alone
          c_d         = COMP_W'(m_q);
          prev_d      = COMP_W'(m_q);
          have_prev_d = 1'b1;
          res_sv_d    = 1'b0;
          state_d     = BK_EMIT;
        end else if ({1'b0, bat_q} >= bat_thresh) begin
          c_d     = COMP_W'(m_q);
          state_d = BK_MUL_NEW;
        end else if (bat_q <= BAT_W'(cfg_i.dropout_mv)) begin
          c_d     = '1;
          state_d = BK_MUL_NEW;
        end else begin
          div_start = 1'b1;
          state_d   = BK_CDIV;
        end
      end
      BK_CDIV: begin
        if (div_done) begin
          c_d     = (|div_quo[DVD_W-1:COMP_W]) ? '1 : div_quo[COMP_W-1:0];
          state_d = BK_MUL_NEW;
        end
      end
      BK_MUL_NEW: begin
        prod_d  = mul_p;
        acc_d   = '0;
        state_d = BK_MUL_PREV;
      end
      BK_MUL_PREV: begin
        mul_a   = cfg_i.coef_prev;
        mul_b   = {prev_q, 8'b0};
        prod_d  = mul_p;
        acc_d   = acc_sum;
        state_d = BK_MUL_FB;
      end
      BK_MUL_FB: begin
        mul_a   = cfg_i.coef_feedback;
        mul_b   = filt_q;
        prod_d  = mul_p;
        acc_d   = acc_sum;
        state_d = BK_FINISH;
      end
      BK_FINISH: begin
        // drop 16 fraction bits, saturate to the Q16.8 range
        filt_d   = (|acc_sum[ACC_W-1:FILT_W+16]) ? '1 : acc_sum[FILT_W+15:16];
        prev_d   = c_q;
        res_sv_d = 1'b1;
        state_d  = BK_EMIT;
      end
      BK_EMIT: begin
        if (!out_valid_q || pop_i) begin
          load_out = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      least_q     <= '1;
      wd_q        <= '0;
      prev_q      <= '0;
      filt_q      <= '0;
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      least_q     <= least_d;
      wd_q        <= wd_d;
      prev_q      <= prev_d;
      filt_q      <= filt_d;
      have_prev_q <= have_prev_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bat_q    <= bat_d;
    trim_q   <= trim_d;
    m_q      <= m_d;
    c_q      <= c_d;
    res_sv_q <= res_sv_d;
    prod_q   <= prod_d;
    acc_q    <= acc_d;
    if (load_out) begin
      out_comp_q   <= c_q;
      out_smooth_q <= res_sv_q ? filt_q : '0;
      out_sv_q     <= res_sv_q;
    end
  end

  assign empty_o           = !out_valid_q;
  assign compensated_min_o = out_comp_q;
  assign smoothed_o        = out_smooth_q;
  assign smoothed_valid_o  = out_sv_q;

endmodule

`default_nettype wire

// ===== rtl/trimmed_mean_min_smoother_core.sv =====
// ----------------------------------------------------------------------------
// trimmed_mean_min_smoother_core
// Trimmed-mean decimator with least-mean aggregation, battery compensation
// and three-term IIR smoothing.
// ----------------------------------------------------------------------------
// Input side is a queue write port: an item (sample_mv_i, battery_mv_i) is
// taken on a clock edge with push high and full low. The front takes one item
// per cycle as long as the 4-entry window queue has room; each window of
// SAMPLES_PER_WINDOW items queues one trimmed numerator.
// Per window the back pops with a reciprocal multiply for the divide by
// SAMPLES_PER_WINDOW-2, then does the least-mean update. The first result
// after reset goes straight to the load; later ones take the restoring
// divider when compensation is due, three passes through one 16x24 multiplier
// and the load. At the default aggregation count the block keeps up with one
// item per cycle and full only rises when results wait; a small count makes
// it rise too. Results come out of a queue read port: while empty is low the
// oldest result sits on the output ports and is taken with pop. One result is
// held; while it waits the back keeps working on windows and only stalls at
// the next result, after which the window queue and then full back up.
// Reset clears all window, aggregation and filter state and loads the
// register defaults; the first result after reset is uncompensated and
// carries smoothed_valid_o low. Config writes (cfg_we_i) take effect at once.
// ----------------------------------------------------------------------------
`default_nettype none

module trimmed_mean_min_smoother_core import tmms_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [SAMPLE_W-1:0]   sample_mv_i,
  input  wire logic [BAT_W-1:0]      battery_mv_i,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [COMP_W-1:0]          compensated_min_o,
  output logic [FILT_W-1:0]          smoothed_o,
  output logic                       smoothed_valid_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q;
  logic wq_full, wq_push, wq_empty, wq_pop;
  win_t wq_wdata, wq_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.agg_count     <= AGG_W'(8);
      cfg_q.coef_new      <= COEF_W'(8192);
      cfg_q.coef_prev     <= COEF_W'(8192);
      cfg_q.coef_feedback <= COEF_W'(49152);
      cfg_q.nominal_mv    <= NOM_W'(3300);
      cfg_q.dropout_mv    <= DROP_W'(190);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_AGG_COUNT:     cfg_q.agg_count     <= cfg_data_i[AGG_W-1:0];
        REG_COEF_NEW:      cfg_q.coef_new      <= cfg_data_i[COEF_W-1:0];
        REG_COEF_PREV:     cfg_q.coef_prev     <= cfg_data_i[COEF_W-1:0];
        REG_COEF_FEEDBACK: cfg_q.coef_feedback <= cfg_data_i[COEF_W-1:0];
        REG_NOMINAL_MV:    cfg_q.nominal_mv    <= cfg_data_i[NOM_W-1:0];
        REG_DROPOUT_MV:    cfg_q.dropout_mv    <= cfg_data_i[DROP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tmms_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .sample_mv_i  (sample_mv_i),
    .battery_mv_i (battery_mv_i),
    .full_o       (full),
    .wq_full_i    (wq_full),
    .wq_push_o    (wq_push),
    .wq_data_o    (wq_wdata)
  );

  tmms_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (wq_push),
    .data_i  (wq_wdata),
    .full_o  (wq_full),
    .pop_i   (wq_pop),
    .empty_o (wq_empty),
    .data_o  (wq_rdata)
  );

  tmms_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .wq_empty_i        (wq_empty),
    .wq_data_i         (wq_rdata),
    .wq_pop_o          (wq_pop),
    .empty_o           (empty),
    .pop_i             (pop),
    .compensated_min_o (compensated_min_o),
    .smoothed_o        (smoothed_o),
    .smoothed_valid_o  (smoothed_valid_o)
  );

endmodule

`default_nettype wire
